/* sv/dcm_pkg.sv */
// shared types, command codes and the mixing function of the drive command decoder
package dcm_pkg;

  localparam logic [7:0] CmdStopByte  = 8'h73;
  localparam logic [7:0] CmdDriveByte = 8'h63;

  localparam logic [1:0] DirFwd   = 2'h1;
  localparam logic [1:0] DirBwd   = 2'h2;
  localparam logic [1:0] DirBrake = 2'h3;

  localparam logic [7:0] DutyMax = 8'd255;

  localparam int QDepth   = 2;
  localparam int QAw      = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    OP_STOP,
    OP_DRIVE,
    OP_MIX
  } dcm_op_t;

  typedef struct packed {
    dcm_op_t            op;
    logic signed [8:0]  left_sum;
    logic signed [8:0]  right_sum;
  } dcm_cmd_t;

  typedef struct packed {
    logic [1:0] dir;
    logic [7:0] duty;
  } dcm_side_t;

  // twice the magnitude, saturated; negative sum drives forward
  function automatic dcm_side_t mix_side(logic signed [8:0] sum);
    dcm_side_t  res;
    logic [8:0] mag;
    mag = sum[8] ? 9'(-sum) : 9'(sum);
    res.dir = sum[8] ? DirFwd : DirBwd;
    if (mag[8:7] != 2'b00) begin
      res.duty = DutyMax;
    end else begin
      res.duty = {mag[6:0], 1'b0};
    end
    return res;
  endfunction

endpackage

/* sv/dcm_front.sv */
// front end: arming, command phase tracking and command classification
module dcm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_rx_byte,
  input  logic             q_full,
  output logic             q_push,
  output dcm_pkg::dcm_cmd_t q_data
);
  import dcm_pkg::*;

  typedef enum logic [1:0] {
    PH_CMD,
    PH_X,
    PH_Y,
    PH_Z
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic       armed_r, armed_nxt;
  logic [7:0] held_turn_r, held_turn_nxt;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_nxt      = phase_r;
    armed_nxt      = armed_r;
    held_turn_nxt  = held_turn_r;
    q_push         = 1'b0;
    q_data.op      = OP_STOP;
    q_data.left_sum  = {in_rx_byte[7], in_rx_byte} + {held_turn_r[7], held_turn_r};
    q_data.right_sum = {in_rx_byte[7], in_rx_byte} - {held_turn_r[7], held_turn_r};
    if (accept) begin
      if (!armed_r) begin
        if (in_rx_byte == CmdStopByte) begin
          armed_nxt = 1'b1;
        end
      end else begin
        case (phase_r)
          PH_CMD: begin
            if (in_rx_byte == CmdStopByte) begin
              q_push    = 1'b1;
              q_data.op = OP_STOP;
            end else if (in_rx_byte == CmdDriveByte) begin
              q_push    = 1'b1;
              q_data.op = OP_DRIVE;
              phase_nxt = PH_X;
            end
          end
          PH_X: begin
            phase_nxt = PH_Y;
          end
          PH_Y: begin
            held_turn_nxt = in_rx_byte;
            phase_nxt     = PH_Z;
          end
          PH_Z: begin
            q_push    = 1'b1;
            q_data.op = OP_MIX;
            phase_nxt = PH_CMD;
          end
          default: begin
            phase_nxt = PH_CMD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CMD;
      armed_r     <= 1'b0;
      held_turn_r <= 8'd0;
    end else begin
      phase_r     <= phase_nxt;
      armed_r     <= armed_nxt;
      held_turn_r <= held_turn_nxt;
    end
  end

  // a command sequence can only be under way once armed
  a_phase_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_CMD) |-> armed_r)
    else $error("command phase advanced while unarmed");

endmodule

/* sv/dcm_queue.sv */
// short command queue between the front end and the drive back end
module dcm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dcm_pkg::dcm_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output dcm_pkg::dcm_cmd_t pop_data
);
  import dcm_pkg::*;

  dcm_cmd_t         mem_r [QDepth];
  logic [QAw-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAw-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCntW'(QDepth));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  function automatic logic [QAw-1:0] ptr_inc(logic [QAw-1:0] p);
    if (p == QAw'(QDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue read while empty");

endmodule

/* sv/dcm_back.sv */
// back end: applies queued commands to the drive state, which is also the output register
module dcm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  dcm_pkg::dcm_cmd_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_enable,
  output logic              out_left_in1,
  output logic              out_left_in2,
  output logic [7:0]        out_left_pwm,
  output logic              out_right_in1,
  output logic              out_right_in2,
  output logic [7:0]        out_right_pwm
);
  import dcm_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  logic      driving_r, driving_nxt;
  dcm_side_t left_r, left_nxt;
  dcm_side_t right_r, right_nxt;

  assign q_pop = q_not_empty && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    driving_nxt   = driving_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      case (q_data.op)
        OP_STOP: begin
          driving_nxt = 1'b0;
          left_nxt    = '{dir: DirBrake, duty: 8'd0};
          right_nxt   = '{dir: DirBrake, duty: 8'd0};
        end
        OP_DRIVE: begin
          driving_nxt = 1'b1;
        end
        OP_MIX: begin
          left_nxt  = mix_side(q_data.left_sum);
          right_nxt = mix_side(q_data.right_sum);
        end
        default: begin
          out_valid_nxt = out_valid_r && !out_ready;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      driving_r   <= 1'b0;
      left_r      <= '{dir: DirBrake, duty: 8'd0};
      right_r     <= '{dir: DirBrake, duty: 8'd0};
    end else begin
      out_valid_r <= out_valid_nxt;
      driving_r   <= driving_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_enable    = driving_r;
  assign out_left_in1  = left_r.dir[0];
  assign out_left_in2  = left_r.dir[1];
  assign out_left_pwm  = left_r.duty;
  assign out_right_in1 = right_r.dir[0];
  assign out_right_in2 = right_r.dir[1];
  assign out_right_pwm = right_r.duty;

  // both sides brake together, and only with zero duty
  a_brake_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (left_r.dir == DirBrake) == (right_r.dir == DirBrake))
    else $error("only one side braking");

  a_brake_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (left_r.dir == DirBrake) |-> (left_r.duty == 8'd0 && right_r.duty == 8'd0))
    else $error("nonzero duty while braking");

  a_idle_braked: assert property (@(posedge clk) disable iff (!rst_n)
    !driving_r |-> (left_r.dir == DirBrake))
    else $error("drive moving with enable low");

endmodule

/* sv/drive_command_decoder_mixer.sv */
// Drive command decoder and differential mixer: takes one received byte per cycle whenever the
// two-entry command queue has room, arms on the first 's', then decodes 's' (brake both sides,
// enable low) and 'c' x y z (enable high, left = z + y, right = z - y, duty twice the magnitude
// saturated at 255, negative sum forward). The front end classifies bytes and queues commands;
// the back end applies one queued command per cycle, while its output is free or being taken,
// to the drive state, which doubles as the output register. A result is queued, then registered
// in the drive state and held until taken; bytes keep flowing while a result waits until the queue fills.
module drive_command_decoder_mixer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_enable,
  output logic       out_left_in1,
  output logic       out_left_in2,
  output logic [7:0] out_left_pwm,
  output logic       out_right_in1,
  output logic       out_right_in2,
  output logic [7:0] out_right_pwm
);
  import dcm_pkg::*;

  dcm_cmd_t push_data;
  dcm_cmd_t pop_data;
  logic     push;
  logic     pop;
  logic     full;
  logic     not_empty;

  dcm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (full),
    .q_push     (push),
    .q_data     (push_data)
  );

  dcm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  dcm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (not_empty),
    .q_data        (pop_data),
    .q_pop         (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_enable    (out_enable),
    .out_left_in1  (out_left_in1),
    .out_left_in2  (out_left_in2),
    .out_left_pwm  (out_left_pwm),
    .out_right_in1 (out_right_in1),
    .out_right_in2 (out_right_in2),
    .out_right_pwm (out_right_pwm)
  );

endmodule

/* tb/drive_command_decoder_mixer_tb.sv */
// testbench for the drive command decoder and differential mixer
`timescale 1ns / 100ps

module drive_command_decoder_mixer_tb;
  import dcm_pkg::*;

  typedef enum logic [1:0] {
    AWAIT_CMD,
    AWAIT_X,
    AWAIT_Y,
    AWAIT_Z
  } rx_phase_t;

  typedef struct packed {
    logic       enable;
    logic       left_in1;
    logic       left_in2;
    logic [7:0] left_pwm;
    logic       right_in1;
    logic       right_in2;
    logic [7:0] right_pwm;
  } drive_out_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic       out_enable;
  logic       out_left_in1;
  logic       out_left_in2;
  logic [7:0] out_left_pwm;
  logic       out_right_in1;
  logic       out_right_in2;
  logic [7:0] out_right_pwm;

  drive_command_decoder_mixer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_enable    (out_enable),
    .out_left_in1  (out_left_in1),
    .out_left_in2  (out_left_in2),
    .out_left_pwm  (out_left_pwm),
    .out_right_in1 (out_right_in1),
    .out_right_in2 (out_right_in2),
    .out_right_pwm (out_right_pwm)
  );

  // predicted decoder state
  bit         pred_armed;
  rx_phase_t  pred_phase;
  logic [7:0] pred_turn;
  logic       pred_enable;
  dcm_side_t  pred_left;
  dcm_side_t  pred_right;

  drive_out_t expected_drive[$];
  int         fail_count = 0;
  int         bytes_sent = 0;
  bit         steady = 1'b0;
  bit         hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] data_byte();
    logic [7:0] corners[5];
    corners = '{8'h00, 8'h7f, 8'h80, 8'hff, 8'h01};
    if ($urandom_range(0, 4) == 0) return corners[$urandom_range(0, 4)];
    return 8'($urandom_range(0, 255));
  endfunction

  // duty is twice the magnitude, clipped; negative sum runs forward
  function automatic dcm_side_t mix_sum(int sum);
    dcm_side_t side;
    int        duty;
    duty = (sum < 0 ? -sum : sum) * 2;
    side.dir = (sum < 0) ? DirFwd : DirBwd;
    side.duty = (duty > int'(DutyMax)) ? DutyMax : duty[7:0];
    return side;
  endfunction

  task automatic push_expected();
    drive_out_t e;
    e.enable    = pred_enable;
    e.left_in1  = pred_left.dir[0];
    e.left_in2  = pred_left.dir[1];
    e.left_pwm  = pred_left.duty;
    e.right_in1 = pred_right.dir[0];
    e.right_in2 = pred_right.dir[1];
    e.right_pwm = pred_right.duty;
    expected_drive.push_back(e);
  endtask

  task automatic predict_drive(input logic [7:0] b);
    int turn;
    int speed;
    if (!pred_armed) begin
      if (b == CmdStopByte) pred_armed = 1'b1;
      return;
    end
    case (pred_phase)
      AWAIT_CMD: begin
        if (b == CmdStopByte) begin
          pred_enable = 1'b0;
          pred_left   = '{dir: DirBrake, duty: 8'd0};
          pred_right  = '{dir: DirBrake, duty: 8'd0};
          push_expected();
        end else if (b == CmdDriveByte) begin
          pred_enable = 1'b1;
          pred_phase  = AWAIT_X;
          push_expected();
        end
      end
      AWAIT_X: pred_phase = AWAIT_Y;
      AWAIT_Y: begin
        pred_turn  = b;
        pred_phase = AWAIT_Z;
      end
      default: begin
        turn       = $signed(pred_turn);
        speed      = $signed(b);
        pred_left  = mix_sum(speed + turn);
        pred_right = mix_sum(speed - turn);
        pred_phase = AWAIT_CMD;
        push_expected();
      end
    endcase
  endtask

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  task automatic check_drive(input drive_out_t got);
    drive_out_t want;
    string      diffs;
    if (expected_drive.size() == 0) begin
      log_failure($sformatf("unexpected result en=%b l=%b%b/%0d r=%b%b/%0d", got.enable,
                            got.left_in1, got.left_in2, got.left_pwm, got.right_in1,
                            got.right_in2, got.right_pwm));
      return;
    end
    want = expected_drive.pop_front();
    diffs = "";
    if (got.enable !== want.enable) diffs = {diffs, " enable"};
    if (got.left_in1 !== want.left_in1) diffs = {diffs, " left_in1"};
    if (got.left_in2 !== want.left_in2) diffs = {diffs, " left_in2"};
    if (got.left_pwm !== want.left_pwm) diffs = {diffs, " left_pwm"};
    if (got.right_in1 !== want.right_in1) diffs = {diffs, " right_in1"};
    if (got.right_in2 !== want.right_in2) diffs = {diffs, " right_in2"};
    if (got.right_pwm !== want.right_pwm) diffs = {diffs, " right_pwm"};
    if (diffs != "") begin
      log_failure($sformatf("mismatch in%s: expected en=%b l=%b%b/%0d r=%b%b/%0d, got en=%b l=%b%b/%0d r=%b%b/%0d",
                            diffs, want.enable, want.left_in1, want.left_in2, want.left_pwm,
                            want.right_in1, want.right_in2, want.right_pwm, got.enable,
                            got.left_in1, got.left_in2, got.left_pwm, got.right_in1,
                            got.right_in2, got.right_pwm));
    end
  endtask

  // one byte transaction; returns at the edge where it is taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    predict_drive(b);
  endtask

  task automatic send_drive(input logic [7:0] x, input logic [7:0] y, input logic [7:0] z);
    send_byte(CmdDriveByte);
    send_byte(x);
    send_byte(y);
    send_byte(z);
  endtask

  // receiver side: checks every result and stalls at random
  initial begin : receiver
    int stall_left;
    int g;
    stall_left = 0;
    out_ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        check_drive({out_enable, out_left_in1, out_left_in2, out_left_pwm,
                     out_right_in1, out_right_in2, out_right_pwm});
      end
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 200;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          out_ready  <= 1'b0;
          stall_left = g - 1;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // nothing but 's' may leave the unarmed state, and that arming gives no result
  task automatic test_unarmed();
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(CmdDriveByte);
    send_byte(8'h80);
    send_byte(8'h7f);
    send_byte(CmdStopByte);
  endtask

  task automatic test_directed();
    send_byte(CmdStopByte);
    send_drive(8'h00, 8'h7f, 8'h7f);
    send_drive(8'hff, 8'h80, 8'h80);
    send_drive(8'h5a, 8'h80, 8'h7f);
    send_drive(8'h11, 8'h01, 8'h00);
    // command codes inside a drive sequence are plain data
    send_drive(CmdStopByte, CmdDriveByte, CmdStopByte);
    send_byte(8'h41);
    send_byte(CmdStopByte);
  endtask

  // receiver holds off while drive commands keep coming, so the input stalls
  task automatic test_backpressure();
    steady   = 1'b1;
    hold_req = 1'b1;
    repeat (12) send_drive(data_byte(), data_byte(), data_byte());
    steady = 1'b0;
  endtask

  task automatic test_random();
    int r;
    while (bytes_sent < 1400) begin
      if ($urandom_range(0, 49) == 0) steady = !steady;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_drive(data_byte(), data_byte(), data_byte());
      end else if (r < 82) begin
        send_byte(CmdStopByte);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= 8'h00;
    pred_armed  = 1'b0;
    pred_phase  = AWAIT_CMD;
    pred_turn   = 8'h00;
    pred_enable = 1'b0;
    pred_left   = '{dir: DirBrake, duty: 8'd0};
    pred_right  = '{dir: DirBrake, duty: 8'd0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unarmed();
    test_directed();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/dcm_pkg.sv
sv/dcm_front.sv
sv/dcm_queue.sv
sv/dcm_back.sv
sv/drive_command_decoder_mixer.sv
tb/drive_command_decoder_mixer_tb.sv
